>>> rtl/core/adm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adm_pkg
// Shared types, constants and helpers for the advertising data name matcher.
// ----------------------------------------------------------------------------
package adm_pkg;

    // Longest report that may still produce a match.
    localparam int MAX_REPORT_BYTES = 31;
    // Number of name bytes compared against the configured name.
    localparam int NAME_BYTES = 5;

    localparam int NAME_W = 40;
    localparam logic [NAME_W-1:0] MATCH_NAME_RESET = 40'h54504D5353;

    // AD structure types that carry a local name.
    localparam logic [7:0] AD_TYPE_NAME_SHORT    = 8'h08;
    localparam logic [7:0] AD_TYPE_NAME_COMPLETE = 8'h09;

    // Saturation point of the byte position counter.
    localparam logic [7:0] POS_MAX = 8'hFF;

    // Parser phase, one-hot.
    typedef enum logic [2:0] {
        PH_LEN  = 3'b001,
        PH_TYPE = 3'b010,
        PH_DATA = 3'b100
    } phase_t;

    // One report byte held in the input register.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } step_t;

    // Result of one report.
    typedef struct packed {
        logic found;
        logic too_long;
    } res_t;

    // Expected name byte at a given index; the first byte sits highest.
    // Bytes above the register width compare against zero.
    function automatic logic [7:0] name_byte(input logic [NAME_W-1:0] name,
                                             input logic [2:0] idx);
        logic [63:0] ext;
        logic [63:0] shifted;
        ext     = {{(64-NAME_W){1'b0}}, name};
        shifted = ext >> (8 * (NAME_BYTES - 1 - int'(idx)));
        return shifted[7:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/adm_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adm_in_stage
// Input register for report bytes with a one-deep hold on stall.
// ----------------------------------------------------------------------------
module adm_in_stage
    import adm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] adv_byte
    input  wire logic       s_tlast,   // last
    input  wire logic       advance,
    output step_t           step
);

    logic       valid_reg, valid_next;
    logic [7:0] data_reg;
    logic       last_reg;

    // The register may be refilled whenever it is empty or drains this cycle.
    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload loads on every accepted transaction.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    assign step.valid = valid_reg;
    assign step.data  = data_reg;
    assign step.last  = last_reg;

endmodule
`default_nettype wire

>>> rtl/core/adm_walker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adm_walker
// Length-type-value walker with name compare and the match name register.
// ----------------------------------------------------------------------------
module adm_walker
    import adm_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_tvalid,
    output logic                   cfg_tready,
    input  wire logic [NAME_W-1:0] cfg_tdata,
    input  wire step_t             step,
    input  wire logic              advance,
    output res_t                   res
);

    logic [NAME_W-1:0] match_reg;

    logic [7:0] pos_reg,      pos_next;
    phase_t     phase_reg,    phase_next;
    logic [7:0] left_reg,     left_next;
    logic       cand_reg,     cand_next;
    logic [2:0] idx_reg,      idx_next;
    logic       matching_reg, matching_next;
    logic       found_reg,    found_next;
    logic       stopped_reg,  stopped_next;

    logic [7:0] left_dec;
    logic [7:0] b;
    logic       too_long;

    assign cfg_tready = 1'b1;
    assign b          = step.data;
    assign left_dec   = left_reg - 8'd1;

    // Match name register, written by the configuration channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= MATCH_NAME_RESET;
        end else if (cfg_tvalid) begin
            match_reg <= cfg_tdata;
        end
    end

    // Per-byte parse update.
    always_comb begin
        pos_next      = (pos_reg != POS_MAX) ? pos_reg + 8'd1 : pos_reg;
        phase_next    = phase_reg;
        left_next     = left_reg;
        cand_next     = cand_reg;
        idx_next      = idx_reg;
        matching_next = matching_reg;
        found_next    = found_reg;
        stopped_next  = stopped_reg;

        if (!stopped_reg) begin
            case (phase_reg)
                PH_LEN: begin
                    if (b == 8'd0) begin
                        stopped_next = 1'b1;
                    end else begin
                        left_next  = b;
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    left_next     = left_dec;
                    cand_next     = (b inside {AD_TYPE_NAME_SHORT, AD_TYPE_NAME_COMPLETE}) &&
                                    (left_dec == 8'(NAME_BYTES));
                    idx_next      = 3'd0;
                    matching_next = 1'b1;
                    phase_next    = (left_dec == 8'd0) ? PH_LEN : PH_DATA;
                end
                PH_DATA: begin
                    if (cand_reg) begin
                        if ((int'(idx_reg) >= NAME_BYTES) ||
                            (name_byte(match_reg, idx_reg) != b)) begin
                            matching_next = 1'b0;
                        end
                        idx_next = idx_reg + 3'd1;
                    end
                    left_next = left_dec;
                    if (left_dec == 8'd0) begin
                        if (cand_reg && matching_next) begin
                            found_next = 1'b1;
                        end
                        phase_next = PH_LEN;
                    end
                end
                default: begin
                    phase_next = PH_LEN;
                end
            endcase
        end
    end

    // The result reflects the update made by the final byte itself.
    assign too_long     = int'(pos_next) > MAX_REPORT_BYTES;
    assign res.found    = found_next && !too_long;
    assign res.too_long = too_long;

    // State registers; the final byte of a report clears everything.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= 8'd0;
            phase_reg    <= PH_LEN;
            left_reg     <= 8'd0;
            cand_reg     <= 1'b0;
            idx_reg      <= 3'd0;
            matching_reg <= 1'b0;
            found_reg    <= 1'b0;
            stopped_reg  <= 1'b0;
        end else if (advance) begin
            if (step.last) begin
                pos_reg      <= 8'd0;
                phase_reg    <= PH_LEN;
                left_reg     <= 8'd0;
                cand_reg     <= 1'b0;
                idx_reg      <= 3'd0;
                matching_reg <= 1'b0;
                found_reg    <= 1'b0;
                stopped_reg  <= 1'b0;
            end else begin
                pos_reg      <= pos_next;
                phase_reg    <= phase_next;
                left_reg     <= left_next;
                cand_reg     <= cand_next;
                idx_reg      <= idx_next;
                matching_reg <= matching_next;
                found_reg    <= found_next;
                stopped_reg  <= stopped_next;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/adm_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adm_out_stage
// Result register that holds one report result until the sink takes it.
// ----------------------------------------------------------------------------
module adm_out_stage
    import adm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       load,
    input  wire res_t       res,
    output logic            out_free,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [0] found, [1] too_long, [7:2] zero
);

    logic valid_reg, valid_next;
    res_t res_reg;

    // A new result may enter when the register is empty or is being taken.
    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, res_reg.too_long, res_reg.found};

endmodule
`default_nettype wire

>>> rtl/core/adv_data_name_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// A final report byte passes the input register, then the result register raises m_tvalid.
// Throughput: one report byte per cycle; only a final byte waits on a full result register.
// The figure is set by the single input register feeding the per-byte walker update.
// Reset (synchronous, active low) empties both registers, clears the parse state and
// loads the match name with its reset value.
// ----------------------------------------------------------------------------
// adv_data_name_matcher
// Filters advertising reports for a local name structure equal to a set name.
// ----------------------------------------------------------------------------
module adv_data_name_matcher
    import adm_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,     // [7:0] adv_byte
    input  wire logic              s_tlast,     // last
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,     // [0] found, [1] too_long, [7:2] zero
    input  wire logic              cfg_tvalid,
    output logic                   cfg_tready,
    input  wire logic [NAME_W-1:0] cfg_tdata    // [39:0] match_name
);

    step_t step;
    res_t  res;
    logic  out_free;
    logic  advance;

    // A byte moves on unless it is a final byte facing a full result register.
    assign advance = step.valid && (!step.last || out_free);

    adm_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .advance  (advance),
        .step     (step)
    );

    adm_walker u_walker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_tvalid (cfg_tvalid),
        .cfg_tready (cfg_tready),
        .cfg_tdata  (cfg_tdata),
        .step       (step),
        .advance    (advance),
        .res        (res)
    );

    adm_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && step.last),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

>>> rtl/core/adm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adm_checker
// Port-level checks for the advertising data name matcher.
// ----------------------------------------------------------------------------
module adm_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    // A stalled result transaction stays offered.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A too-long report never reports a match.
    a_no_found_when_long: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("found set on a too-long report");

    // The padding bits of a result are zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:2] == 6'd0))
        else $error("result padding not zero");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind adv_data_name_matcher adm_checker u_adm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

>>> test/tb_adv_data_name_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adv_data_name_matcher
// Streams advertising reports byte by byte into the name matcher and checks
// each found / too_long result against a cycle-free model of the parser.
// Directed reports cover the special cases. Random reports are then sent
// under several match names and several patterns of sender gaps and
// receiver back-pressure.
// ----------------------------------------------------------------------------
module tb_adv_data_name_matcher;
    import adm_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 200;
    localparam int SETTLE_TICKS = 8;
    localparam int PHASE_BYTES  = 80;

    // Result of one report as the checker sees it.
    typedef struct {
        logic found;
        logic too_long;
    } report_result_t;

    // Parser model plus the queue of results still owed by the block.
    class report_filter_model;
        logic [NAME_W-1:0] match_name;
        logic [7:0]        byte_pos;
        phase_t            phase;
        logic [7:0]        bytes_left;
        logic              name_cand;
        logic [2:0]        name_idx;
        logic              name_ok;
        logic              found_flag;
        logic              walk_stopped;
        report_result_t    owed_results[$];
        int                failures;

        function new();
            match_name = MATCH_NAME_RESET;
            failures   = 0;
            clear_report();
        endfunction

        function void clear_report();
            byte_pos     = '0;
            phase        = PH_LEN;
            bytes_left   = '0;
            name_cand    = 1'b0;
            name_idx     = '0;
            name_ok      = 1'b0;
            found_flag   = 1'b0;
            walk_stopped = 1'b0;
        endfunction

        // Name byte k of the configured name; byte 0 is the most significant.
        function logic [7:0] name_at(int k);
            logic [NAME_W-1:0] shifted;
            shifted = match_name >> (8 * (NAME_BYTES - 1 - k));
            return shifted[7:0];
        endfunction

        // Advance the parser by one accepted byte.
        function void take_byte(logic [7:0] b, logic is_last);
            report_result_t res;
            if (byte_pos != POS_MAX)
                byte_pos = byte_pos + 8'd1;
            if (!walk_stopped) begin
                case (phase)
                    PH_LEN: begin
                        if (b == 8'd0) begin
                            walk_stopped = 1'b1;
                        end else begin
                            bytes_left = b;
                            phase      = PH_TYPE;
                        end
                    end
                    PH_TYPE: begin
                        bytes_left = bytes_left - 8'd1;
                        name_cand  = (b == AD_TYPE_NAME_COMPLETE || b == AD_TYPE_NAME_SHORT)
                                     && bytes_left == 8'(NAME_BYTES);
                        name_idx   = '0;
                        name_ok    = 1'b1;
                        phase      = (bytes_left == 8'd0) ? PH_LEN : PH_DATA;
                    end
                    default: begin
                        if (name_cand) begin
                            if (int'(name_idx) >= NAME_BYTES || name_at(int'(name_idx)) != b)
                                name_ok = 1'b0;
                            name_idx = name_idx + 3'd1;
                        end
                        bytes_left = bytes_left - 8'd1;
                        if (bytes_left == 8'd0) begin
                            if (name_cand && name_ok)
                                found_flag = 1'b1;
                            phase = PH_LEN;
                        end
                    end
                endcase
            end
            if (is_last) begin
                res.too_long = (int'(byte_pos) > MAX_REPORT_BYTES);
                res.found    = found_flag && !res.too_long;
                owed_results.push_back(res);
                clear_report();
            end
        endfunction

        // Compare one result transaction with the oldest owed result.
        function void check_result(logic [7:0] data);
            report_result_t exp_res;
            if (owed_results.size() == 0) begin
                $error("result 0x%02h arrived with no report outstanding", data);
                failures++;
                return;
            end
            exp_res = owed_results.pop_front();
            if (data[0] !== exp_res.found) begin
                $error("found: expected %0b, got %0b", exp_res.found, data[0]);
                failures++;
            end
            if (data[1] !== exp_res.too_long) begin
                $error("too_long: expected %0b, got %0b", exp_res.too_long, data[1]);
                failures++;
            end
            if (data[7:2] !== 6'd0) begin
                $error("pad: expected 0, got 0x%02h", data[7:2]);
                failures++;
            end
        endfunction

        function int owed();
            return owed_results.size();
        endfunction
    endclass

    logic              aclk       = 1'b0;
    logic              aresetn    = 1'b0;
    logic              s_tvalid   = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata    = '0;
    logic              s_tlast    = 1'b0;
    logic              m_tvalid;
    logic              m_tready   = 1'b0;
    logic [7:0]        m_tdata;
    logic              cfg_tvalid = 1'b0;
    logic              cfg_tready;
    logic [NAME_W-1:0] cfg_tdata  = '0;

    report_filter_model model;
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    int                 cycle_count    = 0;
    bit                 hold_req       = 1'b0;
    logic               hold_active    = 1'b0;

    always #1 aclk = ~aclk;

    adv_data_name_matcher u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_tvalid (cfg_tvalid),
        .cfg_tready (cfg_tready),
        .cfg_tdata  (cfg_tdata)
    );

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Long receiver hold-off, timed here so the sender keeps running meanwhile.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_active <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_active <= 1'b0;
                hold_req = 1'b0;
            end
        end
    end

    // Result side: check each transaction, then pick the next ready value.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            model.check_result(m_tdata);
        m_tready <= !hold_active && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Offer one byte, with random gaps in front, and wait for its transaction.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        do
            @(posedge aclk);
        while (!s_tready);
        model.take_byte(b, is_last);
    endtask

    task automatic send_report(input logic [7:0] rpt[$], inout int sent);
        for (int i = 0; i < rpt.size(); i++)
            send_byte(rpt[i], i == rpt.size() - 1);
        sent += rpt.size();
    endtask

    // Stop offering and wait until every owed result has come back.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (model.owed() != 0)
            @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic write_match_name(input logic [NAME_W-1:0] value);
        cfg_tvalid <= 1'b1;
        cfg_tdata  <= value;
        do
            @(posedge aclk);
        while (!cfg_tready);
        cfg_tvalid <= 1'b0;
        model.match_name = value;
    endtask

    // One random report: mostly well-formed structures, some noise and damage.
    task automatic build_report(input bit saturating, output logic [7:0] rpt[$]);
        int   kind;
        int   len;
        int   bad_at;
        int   cut;
        int   pad_to;
        logic [7:0] nb;
        rpt = {};
        if (saturating) begin
            repeat (270) rpt.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 10)) rpt.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(1, 3)) begin
            kind = $urandom_range(0, 9);
            if (kind <= 3) begin
                // Name structure of the right size, sometimes with one flipped bit.
                rpt.push_back(8'(NAME_BYTES + 1));
                rpt.push_back($urandom_range(0, 1) ? AD_TYPE_NAME_COMPLETE
                                                   : AD_TYPE_NAME_SHORT);
                bad_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, NAME_BYTES - 1) : -1;
                for (int k = 0; k < NAME_BYTES; k++) begin
                    nb = model.name_at(k);
                    if (k == bad_at)
                        nb = nb ^ (8'd1 << $urandom_range(0, 7));
                    rpt.push_back(nb);
                end
            end else if (kind == 4) begin
                // Name type with the wrong length, carrying a name prefix.
                len = $urandom_range(1, 8);
                if (len == NAME_BYTES + 1)
                    len = NAME_BYTES + 2;
                rpt.push_back(8'(len));
                rpt.push_back($urandom_range(0, 1) ? AD_TYPE_NAME_COMPLETE
                                                   : AD_TYPE_NAME_SHORT);
                for (int k = 0; k < len - 1; k++)
                    rpt.push_back(k < NAME_BYTES ? model.name_at(k)
                                                 : 8'($urandom_range(0, 255)));
            end else if (kind <= 7) begin
                len = $urandom_range(1, 6);
                rpt.push_back(8'(len));
                repeat (len) rpt.push_back(8'($urandom_range(0, 255)));
            end else if (kind == 8) begin
                rpt.push_back(8'd0);
            end else begin
                // Length that runs far beyond any report.
                rpt.push_back(8'($urandom_range(32, 255)));
                rpt.push_back(8'($urandom_range(0, 255)));
            end
        end
        // Cut the tail so a structure is left open at the end.
        if ($urandom_range(0, 5) == 0 && rpt.size() > 1) begin
            cut = $urandom_range(1, rpt.size() - 1);
            repeat (cut) void'(rpt.pop_back());
        end
        // Grow past the maximum report length.
        if ($urandom_range(0, 7) == 0) begin
            pad_to = $urandom_range(MAX_REPORT_BYTES + 1, MAX_REPORT_BYTES + 9);
            while (rpt.size() < pad_to)
                rpt.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Random reports until the byte budget is spent; optional sender pauses.
    task automatic run_random(input int budget, input bit with_pauses, input bit saturating);
        logic [7:0] rpt[$];
        int         sent;
        int         n_rpt;
        sent  = 0;
        n_rpt = 0;
        if (saturating) begin
            build_report(1'b1, rpt);
            send_report(rpt, sent);
        end
        while (sent < budget) begin
            build_report(1'b0, rpt);
            send_report(rpt, sent);
            n_rpt++;
            if (with_pauses && n_rpt % 3 == 0)
                quiesce();
        end
    endtask

    initial begin
        logic [7:0] rpt[$];
        int         sent;
        model = new();
        sent  = 0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed reports under the reset name, no idling.
        write_match_name(MATCH_NAME_RESET);
        rpt = {8'd6, AD_TYPE_NAME_COMPLETE, 8'h54, 8'h50, 8'h4D, 8'h53, 8'h53};
        send_report(rpt, sent);
        rpt = {8'd0};
        send_report(rpt, sent);
        rpt = {8'hFF, AD_TYPE_NAME_SHORT};
        send_report(rpt, sent);
        rpt = {8'd6, AD_TYPE_NAME_SHORT, 8'h54, 8'h50, 8'h4D, 8'h53, 8'hAB};
        send_report(rpt, sent);
        rpt = {8'd2, 8'hFF, 8'd0, 8'd6};
        send_report(rpt, sent);
        rpt = {8'd6, AD_TYPE_NAME_COMPLETE, 8'h54, 8'h50};
        send_report(rpt, sent);
        quiesce();

        // All-zero name, sender idles often.
        write_match_name('0);
        send_idle_pct  = 67;
        recv_stall_pct = 0;
        run_random(PHASE_BYTES, 1'b0, 1'b0);
        quiesce();

        // All-ones name, receiver stalls often.
        write_match_name('1);
        send_idle_pct  = 0;
        recv_stall_pct = 67;
        run_random(PHASE_BYTES, 1'b0, 1'b0);
        quiesce();

        // Random name, both sides idle, plus one report long enough to saturate.
        write_match_name(NAME_W'({$urandom(), $urandom()}));
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        run_random(PHASE_BYTES, 1'b0, 1'b1);
        quiesce();

        // Random name, receiver held off for a long stretch while bytes keep coming.
        write_match_name(NAME_W'({$urandom(), $urandom()}));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b1;
        run_random(PHASE_BYTES, 1'b0, 1'b0);
        quiesce();

        // Back to the reset name, with the sender draining every few reports.
        write_match_name(MATCH_NAME_RESET);
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        run_random(PHASE_BYTES, 1'b1, 1'b0);
        quiesce();

        if (model.failures == 0 && model.owed() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
